// ----- rtl/core/round_robin_task_slot_scheduler_macros.svh -----
// Assertion macros used by the scheduler datapath.
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define RRTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define RRTS_ASSERT_IMPL(lbl, ante, cons)
`define RRTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/rrts_pkg.sv -----
// Shared constants, types and helper functions of the task slot scheduler.
package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TRY_W     = $clog2(NUM_SLOTS + 1);

  localparam int IN_W      = 8;
  localparam int OUT_W     = 24;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_KILL  = 2'd1,
    OP_YIELD = 2'd2,
    OP_EXIT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SLOT    = 3'd1,
    ST_ALLOC_FAIL = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_NO_OTHER   = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scanning;
    logic out_free;
  } stat_t;

  // Round-robin successor of a slot.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] r;
    if (s == IDX_W'(NUM_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + IDX_W'(1);
    end
    return r;
  endfunction

  // Slot number trimmed or extended to the four-bit result field.
  function automatic logic [3:0] slot_field(input logic [IDX_W-1:0] s);
    logic [7:0] w;
    w = 8'(s);
    return w[3:0];
  endfunction

  // Live count trimmed or extended to the five-bit result field.
  function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
    logic [7:0] w;
    w = 8'(c);
    return w[4:0];
  endfunction

endpackage

// ----- rtl/core/round_robin_task_slot_scheduler.sv -----
// Top level of the round-robin task slot scheduler.
//
// The block serves scheduler requests one item at a time. An item arrives on
// the s_ channel (operation, target slot, allocation flag, canary flag) and one
// result item leaves on the m_ channel (status, result slot, previous slot,
// switched flag, live count). Slot 0 is the kernel task and never leaves.
// A kill, or a yield that stops on a broken canary, skips the scan; add,
// yield and exit scan the live bitmap and test one slot of it per cycle
// before the item is committed. s_tready is high only while no item is in
// work and rises in the cycle after an item completes, so a new item is
// accepted only once the block is through with the previous one.
// The result sits in an output register, so the next item is accepted and
// scanned while an earlier result waits; when the receiver stalls, the block
// holds a finished item until the register frees up. Synchronous reset leaves
// only slot 0 live, running and counted, and empties the output register.
module round_robin_task_slot_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: func[1:0], target_slot[5:2], alloc_ok[6], canary_ok[7].
  input  logic [rrts_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: status[2:0], result_slot[6:3], previous_slot[10:7],
  // switched[11], live_count[16:12], zero fill above.
  output logic [rrts_pkg::OUT_W-1:0]    m_tdata
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  logic [2:0] status;
  logic [3:0] result_slot;
  logic [3:0] previous_slot;
  logic       switched;
  logic [4:0] live_count;

  // The controller sequences capture, scan and completion of each item.
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the live bitmap, the running slot and the result register.
  rrts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (s_tdata[1:0]),
    .target_slot   (s_tdata[5:2]),
    .alloc_ok      (s_tdata[6]),
    .canary_ok     (s_tdata[7]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .status        (status),
    .result_slot   (result_slot),
    .previous_slot (previous_slot),
    .switched      (switched),
    .live_count    (live_count)
  );

  assign m_tdata = {7'd0, live_count, switched, previous_slot, result_slot, status};

endmodule

// ----- rtl/core/rrts_ctrl.sv -----
// Control state machine of the task slot scheduler.
module rrts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (!stat.scanning) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Finish only once the result register can take the new item.
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/rrts_dp.sv -----
// Datapath of the task slot scheduler: slot table, scan pointer and result register.
`include "round_robin_task_slot_scheduler_macros.svh"
module rrts_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  rrts_pkg::cmd_t        cmd,
  output rrts_pkg::stat_t       stat,
  input  logic [1:0]            func,
  input  logic [3:0]            target_slot,
  input  logic                  alloc_ok,
  input  logic                  canary_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            status,
  output logic [3:0]            result_slot,
  output logic [3:0]            previous_slot,
  output logic                  switched,
  output logic [4:0]            live_count
);

  // Architectural state.
  logic [rrts_pkg::NUM_SLOTS-1:0] live_map;
  logic [rrts_pkg::IDX_W-1:0]     running;
  logic [rrts_pkg::CNT_W-1:0]     live_total;

  // Per-item working registers.
  logic                           scanning;
  rrts_pkg::op_t                  op_r;
  logic                           alloc_r;
  logic [rrts_pkg::IDX_W-1:0]     prev_r;
  rrts_pkg::status_t              status_r;
  logic [rrts_pkg::IDX_W-1:0]     ptr;
  logic [rrts_pkg::TRY_W-1:0]     tries;
  logic                           find_free;
  logic                           found;

  rrts_pkg::op_t                  in_op;
  logic [rrts_pkg::IDX_W-1:0]     tgt_idx;
  logic                           kill_ok;
  logic                           run_live;
  logic                           overflow;
  logic                           hit;
  logic                           cap_scan;
  rrts_pkg::status_t              cap_status;

  rrts_pkg::status_t              st_c;
  logic [rrts_pkg::IDX_W-1:0]     res_c;
  logic [rrts_pkg::IDX_W-1:0]     running_next;
  logic                           add_c;
  logic [rrts_pkg::CNT_W-1:0]     total_c;

  assign in_op    = rrts_pkg::op_t'(func);
  assign tgt_idx  = rrts_pkg::IDX_W'(target_slot);
  assign run_live = live_map[running];
  assign kill_ok  = (8'(target_slot) != 8'd0) &&
                    (8'(target_slot) < 8'(rrts_pkg::NUM_SLOTS)) && live_map[tgt_idx];
  assign overflow = (running != '0) && run_live && !canary_ok;
  assign hit      = find_free ? !live_map[ptr] : live_map[ptr];

  assign stat.scanning = scanning;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    cap_scan   = 1'b1;
    cap_status = rrts_pkg::ST_OK;
    case (in_op)
      rrts_pkg::OP_KILL: begin
        cap_scan   = 1'b0;
        cap_status = kill_ok ? rrts_pkg::ST_OK : rrts_pkg::ST_IGNORED;
      end
      rrts_pkg::OP_YIELD: begin
        cap_scan   = !overflow;
        cap_status = overflow ? rrts_pkg::ST_OVERFLOW : rrts_pkg::ST_OK;
      end
      default: begin
        cap_scan   = 1'b1;
        cap_status = rrts_pkg::ST_OK;
      end
    endcase
  end

  // Outcome of the item once the scan has ended.
  always_comb begin
    st_c         = rrts_pkg::ST_OK;
    res_c        = running;
    running_next = running;
    add_c        = 1'b0;
    case (op_r)
      rrts_pkg::OP_ADD: begin
        if (!found) begin
          st_c  = rrts_pkg::ST_NO_SLOT;
          res_c = '0;
        end else if (!alloc_r) begin
          st_c  = rrts_pkg::ST_ALLOC_FAIL;
          res_c = '0;
        end else begin
          res_c = ptr;
          add_c = 1'b1;
        end
      end
      rrts_pkg::OP_KILL: begin
        st_c = status_r;
      end
      default: begin
        if (status_r == rrts_pkg::ST_OVERFLOW) begin
          st_c = rrts_pkg::ST_OVERFLOW;
        end else if (found && (ptr != running)) begin
          res_c        = ptr;
          running_next = ptr;
        end else begin
          st_c = rrts_pkg::ST_NO_OTHER;
        end
      end
    endcase
    total_c = add_c ? live_total + rrts_pkg::CNT_W'(1) : live_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_map   <= {{(rrts_pkg::NUM_SLOTS-1){1'b0}}, 1'b1};
      running    <= '0;
      live_total <= rrts_pkg::CNT_W'(1);
      scanning   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        // Kill and the freeing half of exit take effect at once.
        case (in_op)
          rrts_pkg::OP_KILL: begin
            if (kill_ok) begin
              live_map[tgt_idx] <= 1'b0;
              live_total        <= live_total - rrts_pkg::CNT_W'(1);
            end
          end
          rrts_pkg::OP_EXIT: begin
            if ((running != '0) && run_live) begin
              live_map[running] <= 1'b0;
              live_total        <= live_total - rrts_pkg::CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        scanning <= cap_scan;
      end else if (cmd.step && scanning && (hit || (tries == rrts_pkg::TRY_W'(1)))) begin
        scanning <= 1'b0;
      end
      if (cmd.commit) begin
        if (add_c) begin
          live_map[ptr] <= 1'b1;
          live_total    <= total_c;
        end
        running <= running_next;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_op;
      alloc_r   <= alloc_ok;
      prev_r    <= running;
      status_r  <= cap_status;
      found     <= 1'b0;
      find_free <= (in_op == rrts_pkg::OP_ADD);
      ptr       <= (in_op == rrts_pkg::OP_ADD) ? rrts_pkg::IDX_W'(1)
                                               : rrts_pkg::next_slot(running);
      tries     <= (in_op == rrts_pkg::OP_ADD) ? rrts_pkg::TRY_W'(rrts_pkg::NUM_SLOTS - 1)
                                               : rrts_pkg::TRY_W'(rrts_pkg::NUM_SLOTS);
    end else if (cmd.step && scanning) begin
      if (hit) begin
        found <= 1'b1;
      end else if (tries != rrts_pkg::TRY_W'(1)) begin
        ptr   <= rrts_pkg::next_slot(ptr);
        tries <= tries - rrts_pkg::TRY_W'(1);
      end
    end
    if (cmd.commit) begin
      status        <= st_c;
      result_slot   <= rrts_pkg::slot_field(res_c);
      previous_slot <= rrts_pkg::slot_field(prev_r);
      switched      <= (running_next != prev_r);
      live_count    <= rrts_pkg::count_field(total_c);
    end
  end

  `RRTS_ASSERT_IMPL(a_kernel_live, 1'b1, live_map[0])
  `RRTS_ASSERT_IMPL(a_count_matches, 1'b1, $countones(live_map) == int'(live_total))
  `RRTS_ASSERT_IMPL(a_commit_room, cmd.commit, !out_valid || out_ready)
  `RRTS_ASSERT_NEXT(a_run_only_commit, !cmd.commit, $stable(running))

endmodule
